// File: src/cpt_pkg.sv
// Package for the closest-point-on-triangle block: widths, shared types and codes.
// Depends on nothing; every other file of the block refers to it by scoped names.
package cpt_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 24;
    localparam int EW         = COORD_BITS + 1;
    localparam int PW         = 2 * EW;
    localparam int DW         = PW + 2;
    localparam int HW         = DW / 2;
    localparam int QW         = 2 * DW + 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [EW-1:0]         t_diff;
    typedef logic signed [QW-1:0]         t_quad;
    typedef logic [FRAC_BITS:0]           t_frac;

    typedef enum logic [2:0] {
        RG_INTERIOR  = 3'd0,
        RG_HYP       = 3'd1,
        RG_HYP_V2    = 3'd2,
        RG_EDGE_T    = 3'd3,
        RG_CORNER_V0 = 3'd4,
        RG_EDGE_S    = 3'd5,
        RG_HYP_V1    = 3'd6
    } t_region;

    typedef struct packed {
        t_coord [2:0] v0;
        t_diff  [2:0] e0;
        t_diff  [2:0] e1;
    } t_geo;

    typedef struct packed {
        logic  live;
        t_quad num;
        t_quad den;
    } t_lane;

    typedef struct packed {
        t_geo    geo;
        t_region region;
        logic    t_from_s;
        t_lane   lane_s;
        t_lane   lane_t;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// File: src/cpt_in_if.sv
// Input channel of the closest-point block: valid, ready and the query item.
// Depends on cpt_pkg for the coordinate type.
interface cpt_in_if;
    logic            valid;
    logic            ready;
    cpt_pkg::t_coord point_x;
    cpt_pkg::t_coord point_y;
    cpt_pkg::t_coord point_z;
    cpt_pkg::t_coord vert0_x;
    cpt_pkg::t_coord vert0_y;
    cpt_pkg::t_coord vert0_z;
    cpt_pkg::t_coord vert1_x;
    cpt_pkg::t_coord vert1_y;
    cpt_pkg::t_coord vert1_z;
    cpt_pkg::t_coord vert2_x;
    cpt_pkg::t_coord vert2_y;
    cpt_pkg::t_coord vert2_z;

    modport source (output valid, point_x, point_y, point_z, vert0_x, vert0_y, vert0_z,
                    vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, vert0_x, vert0_y, vert0_z,
                  vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, output ready);
endinterface

// File: src/cpt_out_if.sv
// Output channel of the closest-point block: valid, ready and the result item.
// Depends on cpt_pkg for the coordinate type.
interface cpt_out_if;
    logic            valid;
    logic            ready;
    cpt_pkg::t_coord near_x;
    cpt_pkg::t_coord near_y;
    cpt_pkg::t_coord near_z;
    logic [2:0]      region;
    logic            degenerate;

    modport source (output valid, near_x, near_y, near_z, region, degenerate, input ready);
    modport sink (input valid, near_x, near_y, near_z, region, degenerate, output ready);
endinterface

// File: src/closest_point_on_triangle.sv
// Top level of the closest-point-on-triangle block: front pipeline, job queue, back pipeline.
// Depends on cpt_pkg, cpt_in_if, cpt_out_if, cpt_front, cpt_fifo and cpt_back.
//
//   Channel   Dir   Item
//   i_in      in    query point and three vertices, signed Q12.12
//   o_out     out   closest point (saturated), region code, degenerate flag
//
// One item is accepted per cycle and one result leaves per cycle in steady flow.
// The two bit-per-stage divider pipelines in the back set most of the pipeline length.
// Reset clears the stage valid bits and the queue, so items in flight at reset are lost.
// A stall on o_out freezes the back pipeline; the front keeps taking items until the
// four-entry queue between them is full and a job waits in its last stage.
module closest_point_on_triangle (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpt_in_if.sink     i_in,
    cpt_out_if.source  o_out
);
    logic                w_push;
    logic                w_pop;
    cpt_pkg::t_job       w_job_in;
    cpt_pkg::t_job       w_job_out;
    cpt_pkg::t_fifo_stat w_stat;

    cpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (w_push),
        .o_job   (w_job_in),
        .i_stat  (w_stat)
    );

    cpt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_stat  (w_stat)
    );

    cpt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job_out),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );
endmodule

// File: src/cpt_front.sv
// Front pipeline: edge vectors, dot products, det, s and t, region choice and divisions needed.
// Depends on cpt_pkg and cpt_in_if; hands one job per item to the queue.
module cpt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cpt_in_if.sink              i_in,
    output logic                o_push,
    output cpt_pkg::t_job       o_job,
    input  cpt_pkg::t_fifo_stat i_stat
);
    localparam int NS  = 7;
    localparam int EW  = cpt_pkg::EW;
    localparam int PW  = cpt_pkg::PW;
    localparam int DW  = cpt_pkg::DW;
    localparam int DW1 = DW + 1;
    localparam int DW2 = DW + 2;
    localparam int HW  = cpt_pkg::HW;
    localparam int HW1 = HW + 1;
    localparam int QW  = cpt_pkg::QW;
    localparam int QW1 = QW + 1;
    localparam int IA = 0, IB = 1, IC = 2, ID = 3, IE = 4;
    localparam int PAC = 0, PBB = 1, PBE = 2, PCD = 3, PBD = 4, PAE = 5;

    typedef struct packed {
        logic signed [2*HW+1:0] hh;
        logic signed [2*HW+1:0] hl;
        logic signed [2*HW+1:0] lh;
        logic signed [2*HW+1:0] ll;
    } t_part;

    typedef struct packed {
        logic signed [DW-1:0]  a;
        logic signed [DW-1:0]  b;
        logic signed [DW-1:0]  c;
        logic signed [DW-1:0]  d;
        logic signed [DW-1:0]  e;
        logic signed [DW2-1:0] num2;
        logic signed [DW2-1:0] den2;
        logic                  c2;
        logic                  c6;
    } t_aux;

    localparam cpt_pkg::t_lane LANE_OFF = '{live: 1'b0, num: '0, den: '0};

    function automatic t_part part_mul(input logic signed [DW-1:0] x,
                                       input logic signed [DW-1:0] y);
        t_part             r;
        logic signed [HW:0] xh, xl, yh, yl;
        xh   = HW1'($signed(x[DW-1:HW]));
        xl   = $signed({1'b0, x[HW-1:0]});
        yh   = HW1'($signed(y[DW-1:HW]));
        yl   = $signed({1'b0, y[HW-1:0]});
        r.hh = xh * yh;
        r.hl = xh * yl;
        r.lh = xl * yh;
        r.ll = xl * yl;
        return r;
    endfunction

    function automatic cpt_pkg::t_quad part_sum(input t_part p);
        return (QW'(p.hh) <<< (2 * HW)) + (QW'(p.hl) <<< HW) + (QW'(p.lh) <<< HW)
               + QW'(p.ll);
    endfunction

    function automatic cpt_pkg::t_lane mk_lane(input cpt_pkg::t_quad n, input cpt_pkg::t_quad d);
        cpt_pkg::t_lane l;
        l.live = 1'b1;
        l.num  = n;
        l.den  = d;
        return l;
    endfunction

    logic [NS-1:0]         r_vld;
    logic                  w_en;
    cpt_pkg::t_coord       w_p [3];
    cpt_pkg::t_coord       w_v0[3];
    cpt_pkg::t_coord       w_v1[3];
    cpt_pkg::t_coord       w_v2[3];
    cpt_pkg::t_geo         r_geo[NS-1];
    cpt_pkg::t_diff        r_dd[3];
    logic signed [PW-1:0]  r_pr[5][3];
    logic signed [DW-1:0]  r_sum[5];
    t_aux                  r_aux4, r_aux5, r_aux6;
    t_part                 r_pp[6];
    cpt_pkg::t_quad        r_prod[6];
    cpt_pkg::t_quad        r_det, r_s, r_t;
    logic signed [QW:0]    w_st;
    logic                  w_lt, w_sneg, w_tneg;
    cpt_pkg::t_quad        w_a, w_c, w_nd, w_ne, w_n2, w_d2;
    cpt_pkg::t_job         n_job, r_job;

    assign w_en       = !r_vld[NS-1] || !i_stat.full;
    assign i_in.ready = w_en;
    assign o_push     = r_vld[NS-1] && !i_stat.full;
    assign o_job      = r_job;

    assign w_p[0]  = i_in.point_x;
    assign w_p[1]  = i_in.point_y;
    assign w_p[2]  = i_in.point_z;
    assign w_v0[0] = i_in.vert0_x;
    assign w_v0[1] = i_in.vert0_y;
    assign w_v0[2] = i_in.vert0_z;
    assign w_v1[0] = i_in.vert1_x;
    assign w_v1[1] = i_in.vert1_y;
    assign w_v1[2] = i_in.vert1_z;
    assign w_v2[0] = i_in.vert2_x;
    assign w_v2[1] = i_in.vert2_y;
    assign w_v2[2] = i_in.vert2_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_geo[0].v0[k] <= w_v0[k];
                r_geo[0].e0[k] <= EW'(w_v1[k]) - EW'(w_v0[k]);
                r_geo[0].e1[k] <= EW'(w_v2[k]) - EW'(w_v0[k]);
                r_dd[k]        <= EW'(w_v0[k]) - EW'(w_p[k]);
            end
            for (int i = 1; i < NS - 1; i++) begin
                r_geo[i] <= r_geo[i-1];
            end
            for (int k = 0; k < 3; k++) begin
                r_pr[IA][k] <= $signed(r_geo[0].e0[k]) * $signed(r_geo[0].e0[k]);
                r_pr[IB][k] <= $signed(r_geo[0].e0[k]) * $signed(r_geo[0].e1[k]);
                r_pr[IC][k] <= $signed(r_geo[0].e1[k]) * $signed(r_geo[0].e1[k]);
                r_pr[ID][k] <= $signed(r_geo[0].e0[k]) * r_dd[k];
                r_pr[IE][k] <= $signed(r_geo[0].e1[k]) * r_dd[k];
            end
            for (int j = 0; j < 5; j++) begin
                r_sum[j] <= DW'(r_pr[j][0]) + DW'(r_pr[j][1]) + DW'(r_pr[j][2]);
            end
            r_aux4.a    <= r_sum[IA];
            r_aux4.b    <= r_sum[IB];
            r_aux4.c    <= r_sum[IC];
            r_aux4.d    <= r_sum[ID];
            r_aux4.e    <= r_sum[IE];
            r_aux4.num2 <= DW2'(r_sum[IC]) + DW2'(r_sum[IE]) - DW2'(r_sum[IB])
                           - DW2'(r_sum[ID]);
            r_aux4.den2 <= DW2'(r_sum[IA]) - (DW2'(r_sum[IB]) <<< 1) + DW2'(r_sum[IC]);
            r_aux4.c2   <= (DW1'(r_sum[IC]) + DW1'(r_sum[IE]))
                           > (DW1'(r_sum[IB]) + DW1'(r_sum[ID]));
            r_aux4.c6   <= (DW1'(r_sum[IA]) + DW1'(r_sum[ID]))
                           > (DW1'(r_sum[IB]) + DW1'(r_sum[IE]));
            r_pp[PAC]   <= part_mul(r_sum[IA], r_sum[IC]);
            r_pp[PBB]   <= part_mul(r_sum[IB], r_sum[IB]);
            r_pp[PBE]   <= part_mul(r_sum[IB], r_sum[IE]);
            r_pp[PCD]   <= part_mul(r_sum[IC], r_sum[ID]);
            r_pp[PBD]   <= part_mul(r_sum[IB], r_sum[ID]);
            r_pp[PAE]   <= part_mul(r_sum[IA], r_sum[IE]);
            for (int j = 0; j < 6; j++) begin
                r_prod[j] <= part_sum(r_pp[j]);
            end
            r_aux5 <= r_aux4;
            r_det  <= r_prod[PAC] - r_prod[PBB];
            r_s    <= r_prod[PBE] - r_prod[PCD];
            r_t    <= r_prod[PBD] - r_prod[PAE];
            r_aux6 <= r_aux5;
            r_job  <= n_job;
        end
    end

    assign w_st   = QW1'(r_s) + QW1'(r_t);
    assign w_lt   = w_st < QW1'(r_det);
    assign w_sneg = r_s[QW-1];
    assign w_tneg = r_t[QW-1];
    assign w_a    = QW'(r_aux6.a);
    assign w_c    = QW'(r_aux6.c);
    assign w_nd   = -QW'(r_aux6.d);
    assign w_ne   = -QW'(r_aux6.e);
    assign w_n2   = QW'(r_aux6.num2);
    assign w_d2   = QW'(r_aux6.den2);

    always_comb begin
        n_job.geo      = r_geo[NS-2];
        n_job.region   = cpt_pkg::RG_INTERIOR;
        n_job.t_from_s = 1'b0;
        n_job.lane_s   = LANE_OFF;
        n_job.lane_t   = LANE_OFF;
        if (w_lt) begin
            if (w_sneg && w_tneg) begin
                n_job.region = cpt_pkg::RG_CORNER_V0;
                if (r_aux6.d[DW-1]) begin
                    n_job.lane_s = mk_lane(w_nd, w_a);
                end else begin
                    n_job.lane_t = mk_lane(w_ne, w_c);
                end
            end else if (w_sneg) begin
                n_job.region = cpt_pkg::RG_EDGE_T;
                n_job.lane_t = mk_lane(w_ne, w_c);
            end else if (w_tneg) begin
                n_job.region = cpt_pkg::RG_EDGE_S;
                n_job.lane_s = mk_lane(w_nd, w_a);
            end else begin
                n_job.lane_s = mk_lane(r_s, r_det);
                n_job.lane_t = mk_lane(r_t, r_det);
            end
        end else begin
            if (w_sneg) begin
                n_job.region = cpt_pkg::RG_HYP_V2;
                if (r_aux6.c2) begin
                    n_job.lane_s   = mk_lane(w_n2, w_d2);
                    n_job.t_from_s = 1'b1;
                end else begin
                    n_job.lane_t = mk_lane(w_ne, w_c);
                end
            end else if (w_tneg) begin
                n_job.region = cpt_pkg::RG_HYP_V1;
                if (r_aux6.c6) begin
                    n_job.lane_s   = mk_lane(w_n2, w_d2);
                    n_job.t_from_s = 1'b1;
                end else begin
                    n_job.lane_s = mk_lane(w_nd, w_a);
                end
            end else begin
                n_job.region   = cpt_pkg::RG_HYP;
                n_job.lane_s   = mk_lane(w_n2, w_d2);
                n_job.t_from_s = 1'b1;
            end
        end
    end

endmodule

// File: src/cpt_fifo.sv
// Short job queue between the front and back pipelines of the closest-point block.
// Depends on cpt_pkg for the job and status types.
module cpt_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cpt_pkg::t_job       i_data,
    input  logic                i_pop,
    output cpt_pkg::t_job       o_data,
    output cpt_pkg::t_fifo_stat o_stat
);
    localparam int AW = cpt_pkg::FIFO_AW;
    localparam int NW = AW + 1;

    cpt_pkg::t_job r_mem[cpt_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = r_cnt == NW'(cpt_pkg::FIFO_DEPTH);
    assign o_stat.empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full) else $error("job pushed into a full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty) else $error("job popped from an empty queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count did not follow a push");
endmodule

// File: src/cpt_div.sv
// Pipelined restoring divider: fraction bits of num/den for num below den, one bit a stage.
// Depends on cpt_pkg for the operand and quotient widths.
module cpt_div (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [cpt_pkg::QW-1:0]          i_num,
    input  logic [cpt_pkg::QW-1:0]          i_den,
    output logic [cpt_pkg::FRAC_BITS-1:0]   o_quo
);
    localparam int QW = cpt_pkg::QW;
    localparam int FW = cpt_pkg::FRAC_BITS;

    logic [QW-1:0] r_rem[FW];
    logic [QW-1:0] r_den[FW-1];
    logic [FW-1:0] r_quo[FW];
    logic [QW-1:0] n_rem[FW];
    logic [FW-1:0] n_quo[FW];

    for (genvar j = 0; j < FW; j++) begin : g_step
        logic [QW-1:0] w_rin;
        logic [QW-1:0] w_din;
        logic [FW-1:0] w_qin;
        logic [QW:0]   w_sh;
        logic [QW:0]   w_diff;
        logic          w_ge;
        if (j == 0) begin : g_first
            assign w_rin = i_num;
            assign w_din = i_den;
            assign w_qin = '0;
        end else begin : g_next
            assign w_rin = r_rem[j-1];
            assign w_din = r_den[j-1];
            assign w_qin = r_quo[j-1];
        end
        assign w_sh     = {w_rin, 1'b0};
        assign w_diff   = w_sh - {1'b0, w_din};
        assign w_ge     = w_sh >= {1'b0, w_din};
        assign n_rem[j] = w_ge ? w_diff[QW-1:0] : w_sh[QW-1:0];
        assign n_quo[j] = {w_qin[FW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_den[0] <= i_den;
            for (int j = 1; j < FW - 1; j++) begin
                r_den[j] <= r_den[j-1];
            end
        end
    end

    assign o_quo = r_quo[FW-1];
endmodule

// File: src/cpt_back.sv
// Back pipeline: clamps and divides s and t, forms V0 + s*E0 + t*E1, saturates the result.
// Depends on cpt_pkg, cpt_out_if and two cpt_div instances.
module cpt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpt_pkg::t_job       i_job,
    input  cpt_pkg::t_fifo_stat i_stat,
    output logic                o_pop,
    cpt_out_if.source           o_out
);
    localparam int CB  = cpt_pkg::COORD_BITS;
    localparam int FW  = cpt_pkg::FRAC_BITS;
    localparam int EW  = cpt_pkg::EW;
    localparam int QW  = cpt_pkg::QW;
    localparam int LB  = FW + 4;
    localparam int PRW = FW + EW + 2;
    localparam int AW  = CB + FW + 3;

    typedef enum logic [1:0] {LK_ZERO, LK_ONE, LK_DIV} t_kind;

    typedef struct packed {
        cpt_pkg::t_geo    geo;
        cpt_pkg::t_region region;
        logic             t_from_s;
        logic             deg;
        t_kind            ks;
        t_kind            kt;
    } t_side;

    typedef struct packed {
        cpt_pkg::t_geo    geo;
        cpt_pkg::t_region region;
        logic             t_from_s;
        logic             deg;
        cpt_pkg::t_frac   sf;
        cpt_pkg::t_frac   tf;
    } t_comb;

    localparam cpt_pkg::t_frac ONE_F = {1'b1, {FW{1'b0}}};

    function automatic t_kind lane_kind(input cpt_pkg::t_lane l);
        t_kind k;
        if (!l.live || l.den == '0) begin
            k = LK_ZERO;
        end else if (l.num[QW-1] || l.num == '0) begin
            k = LK_ZERO;
        end else if ($signed(l.num) >= $signed(l.den)) begin
            k = LK_ONE;
        end else begin
            k = LK_DIV;
        end
        return k;
    endfunction

    function automatic cpt_pkg::t_frac lane_frac(input t_kind k, input logic [FW-1:0] q);
        cpt_pkg::t_frac f;
        unique case (k)
            LK_ONE:  f = ONE_F;
            LK_DIV:  f = {1'b0, q};
            default: f = '0;
        endcase
        return f;
    endfunction

    logic [LB-1:0]          r_vld;
    logic                   w_en;
    t_side                  n_sb0;
    t_side                  r_sb[FW+1];
    logic [QW-1:0]          r_ns, r_ds, r_nt, r_dt;
    logic [FW-1:0]          w_qs, w_qt;
    t_comb                  n_c, r_c;
    logic signed [PRW-1:0]  r_p0[3], r_p1[3];
    cpt_pkg::t_coord        r_mv0[3];
    cpt_pkg::t_region       r_mreg;
    logic                   r_mdeg;
    logic signed [AW-1:0]   w_acc[3], w_sh[3];
    cpt_pkg::t_coord        n_near[3], r_near[3];
    cpt_pkg::t_region       r_oreg;
    logic                   r_odeg;

    assign w_en  = !r_vld[LB-1] || o_out.ready;
    assign o_pop = w_en && !i_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LB-2:0], o_pop};
        end
    end

    always_comb begin
        n_sb0.geo      = i_job.geo;
        n_sb0.region   = i_job.region;
        n_sb0.t_from_s = i_job.t_from_s;
        n_sb0.deg      = (i_job.lane_s.live && i_job.lane_s.den == '0)
                         || (i_job.lane_t.live && i_job.lane_t.den == '0);
        n_sb0.ks       = lane_kind(i_job.lane_s);
        n_sb0.kt       = lane_kind(i_job.lane_t);
    end

    cpt_div u_div_s (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_ns),
        .i_den (r_ds),
        .o_quo (w_qs)
    );

    cpt_div u_div_t (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_nt),
        .i_den (r_dt),
        .o_quo (w_qt)
    );

    always_comb begin
        n_c.geo      = r_sb[FW].geo;
        n_c.region   = r_sb[FW].region;
        n_c.t_from_s = r_sb[FW].t_from_s;
        n_c.deg      = r_sb[FW].deg;
        n_c.sf       = lane_frac(r_sb[FW].ks, w_qs);
        n_c.tf       = r_sb[FW].t_from_s ? ONE_F - n_c.sf : lane_frac(r_sb[FW].kt, w_qt);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_acc[k] = (AW'(r_mv0[k]) <<< FW) + AW'(r_p0[k]) + AW'(r_p1[k]);
            w_sh[k]  = w_acc[k] >>> FW;
            if (r_mdeg) begin
                n_near[k] = r_mv0[k];
            end else if (&w_sh[k][AW-1:CB-1] || ~|w_sh[k][AW-1:CB-1]) begin
                n_near[k] = w_sh[k][CB-1:0];
            end else if (w_sh[k][AW-1]) begin
                n_near[k] = {1'b1, {(CB-1){1'b0}}};
            end else begin
                n_near[k] = {1'b0, {(CB-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0] <= n_sb0;
            r_ns    <= i_job.lane_s.num;
            r_ds    <= i_job.lane_s.den;
            r_nt    <= i_job.lane_t.num;
            r_dt    <= i_job.lane_t.den;
            for (int i = 1; i <= FW; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
            r_c <= n_c;
            for (int k = 0; k < 3; k++) begin
                r_p0[k]  <= $signed({1'b0, r_c.sf}) * $signed(r_c.geo.e0[k]);
                r_p1[k]  <= $signed({1'b0, r_c.tf}) * $signed(r_c.geo.e1[k]);
                r_mv0[k] <= r_c.geo.v0[k];
            end
            r_mreg <= r_c.region;
            r_mdeg <= r_c.deg;
            r_near <= n_near;
            r_oreg <= r_mreg;
            r_odeg <= r_mdeg;
        end
    end

    assign o_out.valid      = r_vld[LB-1];
    assign o_out.near_x     = r_near[0];
    assign o_out.near_y     = r_near[1];
    assign o_out.near_z     = r_near[2];
    assign o_out.region     = r_oreg;
    assign o_out.degenerate = r_odeg;

    a_edge_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[FW+1] && r_c.t_from_s) |-> (r_c.sf + r_c.tf) == ONE_F)
        else $error("edge fractions do not sum to one");
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[FW+1] |-> (r_c.sf <= ONE_F && r_c.tf <= ONE_F))
        else $error("fraction above one");
    a_pop_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_vld[0]) else $error("popped job did not enter the back pipeline");
endmodule
